// ===== rtl/core/btc_pkg.sv =====
// Shared types, constants and helper functions of the band tuning controller.
package btc_pkg;

  // Band table geometry
  localparam int unsigned NUM_BANDS = 16;
  localparam int unsigned BAND_W    = 4;
  localparam int unsigned FREQ_W    = 31;
  localparam int unsigned DELTA_W   = 32;
  localparam int unsigned SIDE_W    = 8;
  localparam int unsigned ACT_W     = 3;

  // Input tdata layout, lowest bit first
  localparam int unsigned IN_DELTA_LSB = 0;
  localparam int unsigned IN_BAND_LSB  = IN_DELTA_LSB + DELTA_W;
  localparam int unsigned IN_START_LSB = IN_BAND_LSB + BAND_W;
  localparam int unsigned IN_END_LSB   = IN_START_LSB + FREQ_W;
  localparam int unsigned IN_SSB_LSB   = IN_END_LSB + FREQ_W;
  localparam int unsigned IN_SIDE_LSB  = IN_SSB_LSB + FREQ_W;
  localparam int unsigned IN_TX_LSB    = IN_SIDE_LSB + SIDE_W;
  localparam int unsigned IN_USED_W    = IN_TX_LSB + 1;
  localparam int unsigned IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int unsigned OUT_USED_W = FREQ_W + BAND_W + SIDE_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_TUNE   = 3'd0,
    ACT_NEXT   = 3'd1,
    ACT_PREV   = 3'd2,
    ACT_SELECT = 3'd3,
    ACT_LOAD   = 3'd4
  } btc_action_e;

  typedef enum logic [1:0] {
    ADDR_CUR,
    ADDR_NEXT,
    ADDR_PREV,
    ADDR_SEL
  } btc_addr_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TUNE,
    OP_ENTER
  } btc_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } btc_state_e;

  // One band table entry
  typedef struct packed {
    logic [FREQ_W-1:0] lower;
    logic [FREQ_W-1:0] upper;
    logic [FREQ_W-1:0] voice;
    logic [SIDE_W-1:0] side;
  } btc_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    btc_addr_e addr_sel;
    logic      save_we;
    logic      load_we;
    logic      update;
    btc_op_e   op;
  } btc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             transmitting;
    logic             band_ok;
  } btc_sts_t;

  // CW segment test: voice start set and lower <= freq < voice start
  function automatic logic cw_test(input logic [FREQ_W-1:0] freq,
                                   input logic [FREQ_W-1:0] lower,
                                   input logic [FREQ_W-1:0] voice);
    cw_test = (voice != '0) && (freq < voice) && (freq >= lower);
  endfunction

endpackage

// ===== rtl/core/band_tuning_controller.sv =====
// Band tuning controller: one result per transaction, accepted after the previous one is done.
// The band table and band memory reads are registered at the accepting edge; the add, clamp
// and CW test then run in the execute state, and the result register loads once it is free.
// The output register lets a new transaction in while a result waits. Reset (async, active
// low) clears the current band, frequency, sideband, CW flag and the per-entry valid bits,
// so the table and band memory read as zero until written.
module band_tuning_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tune_step, band_number, entry_start, entry_end, entry_ssb_start,
  // entry_sideband, transmitting, zero fill
  input  logic [btc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [btc_pkg::ACT_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // frequency, band_now, sideband_now, cw_mode, zero fill
  output logic [btc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  btc_pkg::btc_cmd_t cmd;
  btc_pkg::btc_sts_t sts;

  btc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  btc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_action_i (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/btc_ctrl.sv =====
// Controller state machine: decodes each transaction and sequences read and update.
module btc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  btc_pkg::btc_sts_t sts_i,
  output btc_pkg::btc_cmd_t cmd_o
);

  btc_pkg::btc_state_e state_q, state_d;
  btc_pkg::btc_op_e    op_q, op_d;
  logic                out_vld_q, out_vld_d;
  logic                out_free;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == btc_pkg::ST_IDLE);
  assign m_axis_tvalid = out_vld_q;

  // State, pending operation and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= btc_pkg::ST_IDLE;
      op_q      <= btc_pkg::OP_NONE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '{capture:  1'b0,
                addr_sel: btc_pkg::ADDR_CUR,
                save_we:  1'b0,
                load_we:  1'b0,
                update:   1'b0,
                op:       btc_pkg::OP_NONE};
    unique case (state_q)
      btc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          op_d          = btc_pkg::OP_NONE;
          state_d       = btc_pkg::ST_EXEC;
          unique case (sts_i.action)
            btc_pkg::ACT_TUNE: begin
              if (!sts_i.transmitting) begin
                op_d = btc_pkg::OP_TUNE;
              end
            end
            btc_pkg::ACT_NEXT: begin
              if (!sts_i.transmitting) begin
                cmd_o.addr_sel = btc_pkg::ADDR_NEXT;
                cmd_o.save_we  = 1'b1;
                op_d           = btc_pkg::OP_ENTER;
              end
            end
            btc_pkg::ACT_PREV: begin
              if (!sts_i.transmitting) begin
                cmd_o.addr_sel = btc_pkg::ADDR_PREV;
                cmd_o.save_we  = 1'b1;
                op_d           = btc_pkg::OP_ENTER;
              end
            end
            btc_pkg::ACT_SELECT: begin
              if (sts_i.band_ok) begin
                cmd_o.addr_sel = btc_pkg::ADDR_SEL;
                op_d           = btc_pkg::OP_ENTER;
              end
            end
            btc_pkg::ACT_LOAD: begin
              cmd_o.load_we = sts_i.band_ok;
            end
            default: begin
              op_d = btc_pkg::OP_NONE;
            end
          endcase
        end
      end
      btc_pkg::ST_EXEC: begin
        cmd_o.op = op_q;
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.update = 1'b1;
          state_d      = btc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = btc_pkg::ST_IDLE;
      end
    endcase
  end

  // Set on a new result, drop when the result transaction completes
  always_comb begin
    out_vld_d = (out_vld_q && !m_axis_tready) || cmd_o.update;
  end

endmodule

// ===== rtl/core/btc_datapath.sv =====
// Datapath: band table, band memory, current tuning state and result register.
module btc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [btc_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [btc_pkg::ACT_W-1:0]         in_action_i,
  input  btc_pkg::btc_cmd_t                 cmd_i,
  output btc_pkg::btc_sts_t                 sts_o,
  output logic [btc_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int unsigned BW = btc_pkg::BAND_W;
  localparam int unsigned FW = btc_pkg::FREQ_W;
  localparam int unsigned SW = btc_pkg::SIDE_W;
  localparam int unsigned DW = btc_pkg::DELTA_W;
  localparam int unsigned NB = btc_pkg::NUM_BANDS;
  localparam int unsigned SUM_W = DW + 2;

  // Unpacked input fields
  logic [DW-1:0] in_delta;
  logic [BW-1:0] in_band;
  logic [FW-1:0] in_start;
  logic [FW-1:0] in_end;
  logic [FW-1:0] in_ssb;
  logic [SW-1:0] in_side;
  logic          in_tx;

  assign in_delta = in_data_i[btc_pkg::IN_DELTA_LSB +: DW];
  assign in_band  = in_data_i[btc_pkg::IN_BAND_LSB +: BW];
  assign in_start = in_data_i[btc_pkg::IN_START_LSB +: FW];
  assign in_end   = in_data_i[btc_pkg::IN_END_LSB +: FW];
  assign in_ssb   = in_data_i[btc_pkg::IN_SSB_LSB +: FW];
  assign in_side  = in_data_i[btc_pkg::IN_SIDE_LSB +: SW];
  assign in_tx    = in_data_i[btc_pkg::IN_TX_LSB];

  assign sts_o.action       = in_action_i;
  assign sts_o.transmitting = in_tx;
  assign sts_o.band_ok      = ({1'b0, in_band} < (BW+1)'(NB));

  // Current tuning state
  logic [BW-1:0] cur_band_q;
  logic [FW-1:0] cur_freq_q;
  logic [SW-1:0] cur_side_q;
  logic          cw_q;
  logic [BW-1:0] band_d;
  logic [FW-1:0] freq_d;
  logic [SW-1:0] side_d;
  logic          cw_d;

  // Captured item fields
  logic [DW-1:0] delta_q;
  logic [BW-1:0] tgt_q;

  // Band step with wrap
  logic [BW-1:0] band_inc;
  logic [BW-1:0] band_dec;
  logic [BW-1:0] rd_addr;

  assign band_inc = (cur_band_q == BW'(NB - 1)) ? '0 : cur_band_q + BW'(1);
  assign band_dec = (cur_band_q == '0) ? BW'(NB - 1) : cur_band_q - BW'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      btc_pkg::ADDR_NEXT: rd_addr = band_inc;
      btc_pkg::ADDR_PREV: rd_addr = band_dec;
      btc_pkg::ADDR_SEL:  rd_addr = in_band;
      default:            rd_addr = cur_band_q;
    endcase
  end

  // Band table: written on load, read at the target band
  btc_pkg::btc_entry_t tbl_mem [NB];
  btc_pkg::btc_entry_t tbl_rd_q;
  logic [NB-1:0]       tbl_vld_q;
  logic                tbl_rd_vld_q;
  btc_pkg::btc_entry_t tbl_wr;
  btc_pkg::btc_entry_t entry;

  assign tbl_wr = '{lower: in_start, upper: in_end, voice: in_ssb, side: in_side};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      tbl_mem[in_band] <= tbl_wr;
    end
    if (cmd_i.capture) begin
      tbl_rd_q <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q    <= '0;
      tbl_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load_we) begin
        tbl_vld_q[in_band] <= 1'b1;
      end
      if (cmd_i.capture) begin
        tbl_rd_vld_q <= tbl_vld_q[rd_addr];
      end
    end
  end

  // Unloaded entries read as zero
  assign entry = tbl_rd_vld_q ? tbl_rd_q : '0;

  // Band memory: saved on band step, preset on load
  logic [FW-1:0] bmem [NB];
  logic [FW-1:0] bmem_rd_q;
  logic [NB-1:0] bmem_vld_q;
  logic          bmem_rd_vld_q;
  logic          bmem_we;
  logic [BW-1:0] bmem_waddr;
  logic [FW-1:0] bmem_wdata;
  logic          bmem_fwd;
  logic [FW-1:0] recall;

  assign bmem_we    = cmd_i.save_we || cmd_i.load_we;
  assign bmem_waddr = cmd_i.load_we ? in_band : cur_band_q;
  assign bmem_wdata = cmd_i.load_we ? ((in_ssb != '0) ? in_ssb : in_start) : cur_freq_q;
  assign bmem_fwd   = bmem_we && (bmem_waddr == rd_addr);

  always_ff @(posedge clk_i) begin
    if (bmem_we) begin
      bmem[bmem_waddr] <= bmem_wdata;
    end
    if (cmd_i.capture) begin
      bmem_rd_q <= bmem_fwd ? bmem_wdata : bmem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmem_vld_q    <= '0;
      bmem_rd_vld_q <= 1'b0;
    end else begin
      if (bmem_we) begin
        bmem_vld_q[bmem_waddr] <= 1'b1;
      end
      if (cmd_i.capture) begin
        bmem_rd_vld_q <= bmem_fwd || bmem_vld_q[rd_addr];
      end
    end
  end

  assign recall = bmem_rd_vld_q ? bmem_rd_q : '0;

  // Capture the step and the target band
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      delta_q <= in_delta;
      tgt_q   <= rd_addr;
    end
  end

  // Tune: wide sum, clamp to band edges
  logic signed [SUM_W-1:0] sum;
  logic                    below;
  logic                    above;
  logic [FW-1:0]           tuned;
  logic                    cw_before;
  logic                    cw_after;

  assign sum   = $signed({(SUM_W-FW)'(0), cur_freq_q})
               + $signed({{(SUM_W-DW){delta_q[DW-1]}}, delta_q});
  assign below = sum < $signed({(SUM_W-FW)'(0), entry.lower});
  assign above = sum > $signed({(SUM_W-FW)'(0), entry.upper});
  assign tuned = below ? entry.lower : (above ? entry.upper : sum[FW-1:0]);

  assign cw_before = btc_pkg::cw_test(cur_freq_q, entry.lower, entry.voice);
  assign cw_after  = btc_pkg::cw_test(tuned, entry.lower, entry.voice);

  // Next tuning state
  always_comb begin
    band_d = cur_band_q;
    freq_d = cur_freq_q;
    side_d = cur_side_q;
    cw_d   = cw_q;
    case (cmd_i.op)
      btc_pkg::OP_TUNE: begin
        freq_d = tuned;
        // flag follows only a change of the CW test
        if (cw_before != cw_after) begin
          cw_d = cw_after;
        end
      end
      btc_pkg::OP_ENTER: begin
        band_d = tgt_q;
        freq_d = recall;
        side_d = entry.side;
        cw_d   = btc_pkg::cw_test(recall, entry.lower, entry.voice);
      end
      default: begin
        cw_d = cw_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_band_q <= '0;
      cur_freq_q <= '0;
      cur_side_q <= '0;
      cw_q       <= 1'b0;
    end else if (cmd_i.update) begin
      cur_band_q <= band_d;
      cur_freq_q <= freq_d;
      cur_side_q <= side_d;
      cw_q       <= cw_d;
    end
  end

  // Result register
  logic [btc_pkg::OUT_USED_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_q <= {cw_d, side_d, band_d, freq_d};
    end
  end

  assign out_data_o = {(btc_pkg::OUT_DATA_W - btc_pkg::OUT_USED_W)'(0), out_q};

endmodule

// ===== rtl/core/btc_checker.sv =====
// Port-level checker for the band tuning controller and its bind.
module btc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [btc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [btc_pkg::ACT_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [btc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_hs;

  assign s_hs = s_axis_tvalid && s_axis_tready;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One transaction in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready)
    else $error("input ready directly after an accepted transaction");

  // Result arrives once the output register is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("result missing after output register freed");

  // Zero fill above the result fields
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[btc_pkg::OUT_DATA_W-1:btc_pkg::OUT_USED_W] == '0)
    else $error("result fill bits not zero");

endmodule

bind band_tuning_controller btc_checker u_btc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tuning_monitor.sv =====
// Channel monitor for the band tuning controller: predicts each result and compares it.
module tuning_monitor
  import btc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  // tune_step, band_number, entry_start, entry_end, entry_ssb_start,
  // entry_sideband, transmitting, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // action
  input  logic [ACT_W-1:0]      s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // frequency, band_now, sideband_now, cw_mode, zero fill
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    err_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [BAND_W-1:0] band;
    logic [SIDE_W-1:0] side;
    logic              cw;
  } radio_view_t;

  // Private copy of the band table and the radio state
  logic [FREQ_W-1:0] tbl_lower  [NUM_BANDS];
  logic [FREQ_W-1:0] tbl_upper  [NUM_BANDS];
  logic [FREQ_W-1:0] tbl_voice  [NUM_BANDS];
  logic [SIDE_W-1:0] tbl_side   [NUM_BANDS];
  logic [FREQ_W-1:0] tbl_memory [NUM_BANDS];
  logic [BAND_W-1:0] cur_band;
  logic [FREQ_W-1:0] cur_freq;
  logic [SIDE_W-1:0] cur_side;
  logic              cur_cw;

  radio_view_t expected_views [$];
  int          result_idx;

  initial err_count_o = 0;
  initial pending_o = 0;

  // Frequency lies between the lower edge and a nonzero voice start
  function automatic logic in_cw_segment(input logic [FREQ_W-1:0] freq,
                                         input logic [BAND_W-1:0] band);
    return (tbl_voice[band] != '0) && (freq < tbl_voice[band]) &&
           (freq >= tbl_lower[band]);
  endfunction

  // Recall a band: its memory, its sideband and a fresh CW flag
  task automatic tune_to_band(input logic [BAND_W-1:0] band);
    cur_band = band;
    cur_freq = tbl_memory[band];
    cur_side = tbl_side[band];
    cur_cw   = in_cw_segment(cur_freq, band);
  endtask

  // Apply one command to the state and queue the resulting view
  task automatic step_radio(input logic [ACT_W-1:0] act, input logic [IN_DATA_W-1:0] data);
    logic [DELTA_W-1:0] delta;
    logic [BAND_W-1:0]  band;
    logic [FREQ_W-1:0]  lo;
    logic [FREQ_W-1:0]  hi;
    logic [FREQ_W-1:0]  voice;
    logic [SIDE_W-1:0]  side;
    logic               tx;
    logic               was_cw;
    logic               now_cw;
    longint             sum;
    radio_view_t        view;
    delta = data[IN_DELTA_LSB +: DELTA_W];
    band  = data[IN_BAND_LSB +: BAND_W];
    lo    = data[IN_START_LSB +: FREQ_W];
    hi    = data[IN_END_LSB +: FREQ_W];
    voice = data[IN_SSB_LSB +: FREQ_W];
    side  = data[IN_SIDE_LSB +: SIDE_W];
    tx    = data[IN_TX_LSB];
    case (act)
      ACT_TUNE: begin
        if (!tx) begin
          was_cw = in_cw_segment(cur_freq, cur_band);
          // wide sum, then clamp: lower edge wins over upper edge
          sum = longint'(cur_freq) + longint'($signed(delta));
          if (sum < longint'(tbl_lower[cur_band])) cur_freq = tbl_lower[cur_band];
          else if (sum > longint'(tbl_upper[cur_band])) cur_freq = tbl_upper[cur_band];
          else cur_freq = sum[FREQ_W-1:0];
          now_cw = in_cw_segment(cur_freq, cur_band);
          if (was_cw != now_cw) cur_cw = now_cw;
        end
      end
      ACT_NEXT, ACT_PREV: begin
        if (!tx) begin
          tbl_memory[cur_band] = cur_freq;
          if (act == ACT_NEXT) begin
            tune_to_band((cur_band == BAND_W'(NUM_BANDS - 1)) ? '0 : cur_band + 1'b1);
          end else begin
            tune_to_band((cur_band == '0) ? BAND_W'(NUM_BANDS - 1) : cur_band - 1'b1);
          end
        end
      end
      ACT_SELECT: begin
        if (band < NUM_BANDS) tune_to_band(band);
      end
      ACT_LOAD: begin
        // table write only; the live frequency and flags stay as they are
        if (band < NUM_BANDS) begin
          tbl_lower[band]  = lo;
          tbl_upper[band]  = hi;
          tbl_voice[band]  = voice;
          tbl_side[band]   = side;
          tbl_memory[band] = (voice != '0) ? voice : lo;
        end
      end
      default: ;
    endcase
    view.freq = cur_freq;
    view.band = cur_band;
    view.side = cur_side;
    view.cw   = cur_cw;
    expected_views.push_back(view);
  endtask

  // Print one mismatch line and count it
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("tuning_monitor: result %0d %s: got 0x%0h, expected 0x%0h",
             result_idx, what, got, want);
    err_count_o++;
  endtask

  // Watch both channels; check outgoing results before taking new commands
  always @(posedge clk_i or negedge rst_ni) begin : watch
    radio_view_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        tbl_lower[i]  = '0;
        tbl_upper[i]  = '0;
        tbl_voice[i]  = '0;
        tbl_side[i]   = '0;
        tbl_memory[i] = '0;
      end
      cur_band   = '0;
      cur_freq   = '0;
      cur_side   = '0;
      cur_cw     = 1'b0;
      result_idx = 0;
      expected_views.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_views.size() == 0) begin
          flag_mismatch("with no prediction pending", m_tdata_i[31:0], '0);
        end else begin
          want = expected_views.pop_front();
          if (m_tdata_i[FREQ_W-1:0] !== want.freq)
            flag_mismatch("frequency", m_tdata_i[FREQ_W-1:0], want.freq);
          if (m_tdata_i[FREQ_W +: BAND_W] !== want.band)
            flag_mismatch("band_now", m_tdata_i[FREQ_W +: BAND_W], want.band);
          if (m_tdata_i[FREQ_W+BAND_W +: SIDE_W] !== want.side)
            flag_mismatch("sideband_now", m_tdata_i[FREQ_W+BAND_W +: SIDE_W], want.side);
          if (m_tdata_i[FREQ_W+BAND_W+SIDE_W] !== want.cw)
            flag_mismatch("cw_mode", m_tdata_i[FREQ_W+BAND_W+SIDE_W], want.cw);
        end
        result_idx++;
      end
      if (s_tvalid_i && s_tready_i) step_radio(s_tuser_i, s_tdata_i);
    end
    pending_o = expected_views.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the band tuning controller: clock, reset, stimulus and verdict.
module tb_top;
  import btc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES  = 200_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam logic [FREQ_W-1:0] F_MAX   = '1;

  // Action codes the block does not use
  localparam logic [ACT_W-1:0] ACT_SPARE0 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE1 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE2 = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [ACT_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int          err_count;
  int          pending;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  band_tuning_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tuning_monitor monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result sink: random stalls, a calm stretch and one long hold-off
  initial begin : sink
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Offer one command after a random gap and hold it until the transaction
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [DELTA_W-1:0] delta,
                          input logic [BAND_W-1:0] band, input logic [FREQ_W-1:0] lo,
                          input logic [FREQ_W-1:0] hi, input logic [FREQ_W-1:0] voice,
                          input logic [SIDE_W-1:0] side, input logic tx);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[IN_DELTA_LSB +: DELTA_W] = delta;
    data[IN_BAND_LSB +: BAND_W]   = band;
    data[IN_START_LSB +: FREQ_W]  = lo;
    data[IN_END_LSB +: FREQ_W]    = hi;
    data[IN_SSB_LSB +: FREQ_W]    = voice;
    data[IN_SIDE_LSB +: SIDE_W]   = side;
    data[IN_TX_LSB]               = tx;
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Random command: mostly well-formed band entries and small steps
  task automatic send_random;
    int unsigned       pick;
    logic [ACT_W-1:0]  act;
    logic [DELTA_W-1:0] delta;
    logic [FREQ_W-1:0] lo;
    logic [FREQ_W-1:0] hi;
    logic [FREQ_W-1:0] voice;
    int unsigned       span;
    pick = $urandom_range(0, 99);
    if (pick < 35) act = ACT_TUNE;
    else if (pick < 47) act = ACT_NEXT;
    else if (pick < 59) act = ACT_PREV;
    else if (pick < 71) act = ACT_SELECT;
    else if (pick < 93) act = ACT_LOAD;
    else if (pick < 95) act = ACT_SPARE0;
    else if (pick < 98) act = ACT_SPARE1;
    else act = ACT_SPARE2;
    if ($urandom_range(0, 9) < 7) begin
      delta = DELTA_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
    end else begin
      delta = $urandom;
    end
    if ($urandom_range(0, 9) < 8) begin
      span  = $urandom_range(1, 1 << 16);
      lo    = FREQ_W'($urandom_range(0, 32'h7FF0_0000));
      hi    = lo + FREQ_W'(span);
      voice = ($urandom_range(0, 3) == 0) ? '0 : lo + FREQ_W'($urandom_range(0, span));
    end else begin
      lo    = FREQ_W'($urandom);
      hi    = FREQ_W'($urandom);
      voice = FREQ_W'($urandom);
    end
    send_cmd(act, delta, BAND_W'($urandom), lo, hi, voice, SIDE_W'($urandom),
             $urandom_range(0, 99) < 15);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tune on an empty table clamps to zero
    send_cmd(ACT_TUNE, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    // Band with a CW segment, then recall it
    send_cmd(ACT_LOAD, '0, 4'd0, 31'd7_000_000, 31'd7_300_000, 31'd7_125_000, 8'hA5, 1'b0);
    send_cmd(ACT_SELECT, '0, 4'd0, '0, '0, '0, '0, 1'b0);
    // Step into the CW segment, clamp low, clamp high
    send_cmd(ACT_TUNE, -32'sd100_000, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_TUNE, 32'h8000_0000, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_TUNE, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_TUNE, '0, '0, '0, '0, '0, '0, 1'b0);
    // Extreme entries: top band at full scale, one without a voice segment
    send_cmd(ACT_LOAD, '0, 4'd15, F_MAX, F_MAX, '0, 8'hFF, 1'b0);
    send_cmd(ACT_LOAD, '0, 4'd1, 31'd14_000_000, 31'd14_350_000, '0, 8'h5A, 1'b0);
    // Band stepping with wrap in both directions
    send_cmd(ACT_NEXT, '0, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_PREV, '0, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_PREV, '0, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_NEXT, '0, '0, '0, '0, '0, '0, 1'b0);
    // Keyed transmitter blocks tune and stepping
    send_cmd(ACT_TUNE, 32'd1000, '0, '0, '0, '0, '0, 1'b1);
    send_cmd(ACT_NEXT, '0, '0, '0, '0, '0, '0, 1'b1);
    send_cmd(ACT_PREV, '0, '0, '0, '0, '0, '0, 1'b1);
    // Load and select still work while keyed; inverted edges
    send_cmd(ACT_LOAD, '0, 4'd2, 31'd5_000_000, 31'd3_000_000, 31'd4_000_000, 8'h3C, 1'b1);
    send_cmd(ACT_SELECT, '0, 4'd2, '0, '0, '0, '0, 1'b1);
    send_cmd(ACT_TUNE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_TUNE, 32'd100, '0, '0, '0, '0, '0, 1'b0);
    // Voice start at full scale, step down into CW
    send_cmd(ACT_LOAD, '0, 4'd3, '0, F_MAX, F_MAX, '0, 1'b0);
    send_cmd(ACT_SELECT, '0, 4'd3, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_TUNE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    // Unused codes only report state
    send_cmd(ACT_SPARE0, $urandom, 4'd7, F_MAX, F_MAX, F_MAX, 8'hFF, 1'b1);
    send_cmd(ACT_SPARE1, $urandom, 4'd8, '0, '0, '0, '0, 1'b0);
    send_cmd(ACT_SPARE2, $urandom, 4'd9, F_MAX, '0, F_MAX, 8'h81, 1'b0);

    // Random traffic in phases: plain, calm, sink hold-off, drain, plain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) calm = 1'b1;
      if (n == 450) begin
        calm = 1'b0;
        hold_req = 1'b1;
      end
      if (n == 500) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      send_random();
    end

    // Drain, then linger a little for stray results
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== band_tuning_controller.f =====
rtl/core/btc_pkg.sv
rtl/core/btc_ctrl.sv
rtl/core/btc_datapath.sv
rtl/core/band_tuning_controller.sv
rtl/core/btc_checker.sv
sim/tuning_monitor.sv
sim/tb_top.sv
